// ----- rtl/tpsdg_pkg.sv -----
// tpsdg_pkg: constants, types and the quarter-wave sine table of the three-phase duty generator
// depends on nothing; used by every module of the block

package tpsdg_pkg;

    // sizing
    localparam int PHASE_BITS       = 32;
    localparam int TABLE_INDEX_BITS = 10;
    localparam int DUTY_HALF        = 250;

    localparam int COUNT_W       = 32;
    localparam int FREQ_W        = 32;
    localparam int DUTY_W        = 9;
    localparam int PROD_W        = 64;
    localparam int VALUE_W       = 16;
    localparam int QUARTER_SHIFT = TABLE_INDEX_BITS - 2;
    localparam int QUARTER_SIZE  = 1 << QUARTER_SHIFT;
    localparam int ANGLE_W       = QUARTER_SHIFT + 1;
    localparam int WHOLE_W       = $clog2(DUTY_HALF + 1);

    // pi/2 in Q62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // one third of a turn, rounded
    localparam logic [PROD_W-1:0] THIRD_FULL =
        ((PROD_W'(1) << PHASE_BITS) + PROD_W'(1)) / PROD_W'(3);
    localparam logic [PHASE_BITS-1:0] PHASE_THIRD = THIRD_FULL[PHASE_BITS-1:0];

    typedef logic [WHOLE_W-1:0] t_whole;
    typedef logic [WHOLE_W:0]   t_rom_entry;  // {fraction non-zero, whole part}
    typedef t_rom_entry         t_quarter_rom [QUARTER_SIZE];

    typedef struct packed {
        logic load_in;
        logic load_phase;
    } t_stage_en;

    // (a*b) >> s, result assumed to fit in 64 bits
    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[s +: 64];
    endfunction

    // unsigned long division, used only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            rem = {rem[63:0], n[bit_i]};
            if (rem >= {1'b0, d}) begin
                rem      = rem - {1'b0, d};
                q[bit_i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sine in Q62 of an angle in Q62 between 0 and pi/2, odd power series
    function automatic logic [63:0] sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        x2   = mul_shr(x, x, 62);
        term = x;
        sum  = x;
        for (int i = 1; i <= 14; i++) begin
            den  = 64'((2 * i) * (2 * i + 1));
            term = div_u64(mul_shr(term, x2, 62), den);
            if ((i & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // floor(DUTY_HALF * sin) split into whole part and fraction flag, first quarter only
    function automatic t_quarter_rom build_quarter_rom();
        t_quarter_rom rom;
        logic [63:0]  s;
        logic [127:0] p;
        logic [63:0]  whole;
        logic         frac;
        for (int k = 0; k < QUARTER_SIZE; k++) begin
            if (k == 0) begin
                s = 64'd0;
            end else begin
                s = sine_q62(mul_shr(HALF_PI_Q62, 64'(k), QUARTER_SHIFT));
            end
            p      = {64'd0, s} * 128'(DUTY_HALF);
            whole  = p[125:62];
            frac   = (p[61:0] != 62'd0);
            rom[k] = {frac, t_whole'(whole)};
        end
        return rom;
    endfunction

    localparam t_quarter_rom QUARTER_ROM = build_quarter_rom();

endpackage

// ----- rtl/three_phase_sine_duty_generator_top.sv -----
// three_phase_sine_duty_generator_top: three-phase sinusoidal PWM compare value generator
// depends on tpsdg_pkg, tpsdg_phase and tpsdg_lookup
// usage
//   each input request is one PWM update tick carrying i_freq_word, the phase step per
//   sample in units of 2^-32 turn; it yields exactly one result request carrying
//   o_duty_a, o_duty_b and o_duty_c (0 to twice the half amplitude), phase b lagging
//   and phase c leading phase a by a third of a turn
//   phase = sample count * frequency word, the count starting at zero, advancing by
//   one per accepted request and wrapping at 2^32
// channels
//   input:  i_valid / o_stall, accepted when i_valid high and o_stall low
//   output: o_valid / i_stall, taken when o_valid high and i_stall low
// timing
//   three register stages: input register, phase product register, result register
//   o_valid rises once the request has passed the input and phase product registers;
//   one request per cycle sustained while i_stall is low; the 32 by 32 multiply sets
//   the stage split
// reset: synchronous active-low, clears the sample count and all stage valids
// back-pressure: i_stall holds the result register; bubbles in the pipe still close
//   up, and o_stall rises only when all three stages hold requests and i_stall is high

module three_phase_sine_duty_generator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [tpsdg_pkg::FREQ_W-1:0] i_freq_word,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [tpsdg_pkg::DUTY_W-1:0] o_duty_a,
    output logic [tpsdg_pkg::DUTY_W-1:0] o_duty_b,
    output logic [tpsdg_pkg::DUTY_W-1:0] o_duty_c
);

    // stage valids
    logic r_v_in;
    logic r_v_phase;
    logic r_v_out;
    logic n_v_in;
    logic n_v_phase;
    logic n_v_out;

    // stage enables, each stage moves when the one after it is free or moving
    logic en_in;
    logic en_phase;
    logic en_out;

    tpsdg_pkg::t_stage_en stage_en;

    logic [tpsdg_pkg::PHASE_BITS-1:0]       phase;
    logic [tpsdg_pkg::PHASE_BITS-1:0]       phase_b;
    logic [tpsdg_pkg::PHASE_BITS-1:0]       phase_c;
    logic [tpsdg_pkg::TABLE_INDEX_BITS-1:0] index_a;
    logic [tpsdg_pkg::TABLE_INDEX_BITS-1:0] index_b;
    logic [tpsdg_pkg::TABLE_INDEX_BITS-1:0] index_c;
    logic [tpsdg_pkg::DUTY_W-1:0]           duty_a;
    logic [tpsdg_pkg::DUTY_W-1:0]           duty_b;
    logic [tpsdg_pkg::DUTY_W-1:0]           duty_c;

    // result register
    logic [tpsdg_pkg::DUTY_W-1:0] r_duty_a;
    logic [tpsdg_pkg::DUTY_W-1:0] r_duty_b;
    logic [tpsdg_pkg::DUTY_W-1:0] r_duty_c;

    always_comb begin
        en_out   = !r_v_out || !i_stall;
        en_phase = !r_v_phase || en_out;
        en_in    = !r_v_in || en_phase;

        stage_en.load_in    = i_valid && en_in;
        stage_en.load_phase = r_v_in && en_phase;

        n_v_in    = en_in ? i_valid : r_v_in;
        n_v_phase = en_phase ? r_v_in : r_v_phase;
        n_v_out   = en_out ? r_v_phase : r_v_out;
    end

    assign o_stall = !en_in;
    assign o_valid = r_v_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in    <= 1'b0;
            r_v_phase <= 1'b0;
            r_v_out   <= 1'b0;
        end else begin
            r_v_in    <= n_v_in;
            r_v_phase <= n_v_phase;
            r_v_out   <= n_v_out;
        end
    end

    // counter, input register and multiplier
    tpsdg_phase u_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (stage_en),
        .i_freq_word (i_freq_word),
        .o_phase     (phase)
    );

    // a third of a turn either side, top bits select the table entry
    always_comb begin
        phase_b = phase - tpsdg_pkg::PHASE_THIRD;
        phase_c = phase + tpsdg_pkg::PHASE_THIRD;
        index_a = phase[tpsdg_pkg::PHASE_BITS-1 -: tpsdg_pkg::TABLE_INDEX_BITS];
        index_b = phase_b[tpsdg_pkg::PHASE_BITS-1 -: tpsdg_pkg::TABLE_INDEX_BITS];
        index_c = phase_c[tpsdg_pkg::PHASE_BITS-1 -: tpsdg_pkg::TABLE_INDEX_BITS];
    end

    tpsdg_lookup u_lookup_a (
        .i_index (index_a),
        .o_duty  (duty_a)
    );

    tpsdg_lookup u_lookup_b (
        .i_index (index_b),
        .o_duty  (duty_b)
    );

    tpsdg_lookup u_lookup_c (
        .i_index (index_c),
        .o_duty  (duty_c)
    );

    always_ff @(posedge i_clk) begin
        if (r_v_phase && en_out) begin
            r_duty_a <= duty_a;
            r_duty_b <= duty_b;
            r_duty_c <= duty_c;
        end
    end

    assign o_duty_a = r_duty_a;
    assign o_duty_b = r_duty_b;
    assign o_duty_c = r_duty_c;

    // back-pressure reaches the input only with a full pipe and a stalled output
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v_in && r_v_phase && r_v_out && i_stall))
        else $error("input stalled while the pipe had room");

    // a request in the phase stage always moves into an empty result register
    a_phase_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_phase && !r_v_out) |=> r_v_out)
        else $error("phase stage request not moved to result register");

    // with no stall an accepted request reaches the output through the input and phase stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted request did not reach the output in time");

endmodule

// ----- rtl/tpsdg_lookup.sv -----
// tpsdg_lookup: one sine table lookup, table index to duty compare value
// depends on tpsdg_pkg (quarter-wave table and sizing)

module tpsdg_lookup (
    input  logic [tpsdg_pkg::TABLE_INDEX_BITS-1:0] i_index,
    output logic [tpsdg_pkg::DUTY_W-1:0]           o_duty
);

    logic [1:0]                          quad;
    logic [tpsdg_pkg::QUARTER_SHIFT-1:0] offset;
    logic [tpsdg_pkg::ANGLE_W-1:0]       angle;
    tpsdg_pkg::t_rom_entry               entry;
    tpsdg_pkg::t_whole                   whole;
    logic                                frac;
    logic [tpsdg_pkg::VALUE_W-1:0]       value;

    always_comb begin
        quad   = i_index[tpsdg_pkg::TABLE_INDEX_BITS-1 -: 2];
        offset = i_index[tpsdg_pkg::QUARTER_SHIFT-1:0];
        // mirror the falling quarters onto the rising one
        if (quad[0]) begin
            angle = tpsdg_pkg::ANGLE_W'(tpsdg_pkg::QUARTER_SIZE) - {1'b0, offset};
        end else begin
            angle = {1'b0, offset};
        end
        entry = tpsdg_pkg::QUARTER_ROM[angle[tpsdg_pkg::QUARTER_SHIFT-1:0]];
        // peak of the wave lies just past the table
        if (angle[tpsdg_pkg::QUARTER_SHIFT]) begin
            whole = tpsdg_pkg::t_whole'(tpsdg_pkg::DUTY_HALF);
            frac  = 1'b0;
        end else begin
            whole = entry[tpsdg_pkg::WHOLE_W-1:0];
            frac  = entry[tpsdg_pkg::WHOLE_W];
        end
        // negative half floors away from the midpoint
        if (quad[1]) begin
            value = tpsdg_pkg::VALUE_W'(tpsdg_pkg::DUTY_HALF) - tpsdg_pkg::VALUE_W'(whole)
                    - tpsdg_pkg::VALUE_W'(frac);
        end else begin
            value = tpsdg_pkg::VALUE_W'(tpsdg_pkg::DUTY_HALF) + tpsdg_pkg::VALUE_W'(whole);
        end
        o_duty = value[tpsdg_pkg::DUTY_W-1:0];
    end

endmodule

// ----- rtl/tpsdg_phase.sv -----
// tpsdg_phase: sample counter, input register and phase multiplier with its register
// depends on tpsdg_pkg (widths, stage enable struct)

module tpsdg_phase (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tpsdg_pkg::t_stage_en             i_en,
    input  logic [tpsdg_pkg::FREQ_W-1:0]     i_freq_word,
    output logic [tpsdg_pkg::PHASE_BITS-1:0] o_phase
);

    logic [tpsdg_pkg::COUNT_W-1:0]    r_count;
    logic [tpsdg_pkg::COUNT_W-1:0]    n_count;
    logic [tpsdg_pkg::COUNT_W-1:0]    r_count_in;
    logic [tpsdg_pkg::FREQ_W-1:0]     r_freq;
    logic [tpsdg_pkg::PROD_W-1:0]     product;
    logic [tpsdg_pkg::PHASE_BITS-1:0] r_phase;

    // counter wraps naturally at its width
    always_comb begin
        n_count = r_count;
        if (i_en.load_in) begin
            n_count = r_count + tpsdg_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_in) begin
            r_count_in <= r_count;
            r_freq     <= i_freq_word;
        end
    end

    assign product = tpsdg_pkg::PROD_W'(r_count_in) * tpsdg_pkg::PROD_W'(r_freq);

    always_ff @(posedge i_clk) begin
        if (i_en.load_phase) begin
            r_phase <= product[tpsdg_pkg::PHASE_BITS-1:0];
        end
    end

    assign o_phase = r_phase;

endmodule
